FILE: hw/rtl/hpm_pkg.sv
// Shared types and constants of the homography forward pixel mapper.
// No dependencies.
package hpm_pkg;

	localparam int COEF_W = 32;
	localparam int CRD_W  = 11;
	localparam int CLR_W  = 8;
	localparam int MUL_W  = 44;	// 32 x 12 signed product
	localparam int SUM_W  = 46;	// two products plus an offset
	localparam int NUM_W  = SUM_W + 10;	// numerator magnitude scaled by 2^10
	localparam int DEN_W  = SUM_W;

	localparam int DEF_DST_WIDTH  = 512;
	localparam int DEF_DST_HEIGHT = 512;
	localparam int DEF_SRC_SPAN   = 2048;

	localparam logic signed [SUM_W-1:0] ONE_Q30 = 46'sd1073741824;

	typedef enum logic [2:0] {
		REG_XX = 3'd0,
		REG_XY = 3'd1,
		REG_XC = 3'd2,
		REG_YX = 3'd3,
		REG_YY = 3'd4,
		REG_YC = 3'd5,
		REG_PX = 3'd6,
		REG_PY = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] xx;
		logic signed [COEF_W-1:0] xy;
		logic signed [COEF_W-1:0] xc;
		logic signed [COEF_W-1:0] yx;
		logic signed [COEF_W-1:0] yy;
		logic signed [COEF_W-1:0] yc;
		logic signed [COEF_W-1:0] px;
		logic signed [COEF_W-1:0] py;
	} coef_t;

	// Magnitudes and signs handed from the MAC stages to the dividers.
	typedef struct packed {
		logic               vld;
		logic [NUM_W-1:0]   num_x;
		logic [NUM_W-1:0]   num_y;
		logic [DEN_W-1:0]   den;
		logic               sgn_x;
		logic               sgn_y;
		logic               den_zero;
		logic               src_ok;
		logic [3*CLR_W-1:0] color;
	} mac_res_t;

endpackage

FILE: hw/rtl/hpm_mac.sv
// Three-stage multiply/sum/magnitude front end of the pixel mapper.
// Depends on hpm_pkg.
module hpm_mac
	import hpm_pkg::*;
#(
	parameter int SRC_SPAN = DEF_SRC_SPAN
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  logic [CRD_W-1:0]   src_col,
	input  logic [CRD_W-1:0]   src_row,
	input  logic [3*CLR_W-1:0] color,
	input  coef_t              coef,
	output mac_res_t           res
);

	logic                      vld_s1, vld_s2, vld_s3;
	logic signed [MUL_W-1:0]   p_xx_s1, p_xy_s1, p_yx_s1, p_yy_s1, p_px_s1, p_py_s1;
	logic signed [COEF_W-1:0]  c_x_s1, c_y_s1;
	logic signed [SUM_W-1:0]   n_x_s2, n_y_s2, d_s2;
	logic                      ok_s1, ok_s2;
	logic [3*CLR_W-1:0]        clr_s1, clr_s2;
	logic signed [MUL_W-1:0]   col_m, row_m;
	logic [NUM_W-1:0]          num_x_s3, num_y_s3;
	logic [DEN_W-1:0]          den_s3;
	logic                      sgn_x_s3, sgn_y_s3, zero_s3, ok_s3;
	logic [3*CLR_W-1:0]        clr_s3;

	assign col_m = $signed(MUL_W'({1'b0, src_col}));
	assign row_m = $signed(MUL_W'({1'b0, src_row}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_xx_s1 <= MUL_W'(coef.xx) * col_m;
			p_xy_s1 <= MUL_W'(coef.xy) * row_m;
			p_yx_s1 <= MUL_W'(coef.yx) * col_m;
			p_yy_s1 <= MUL_W'(coef.yy) * row_m;
			p_px_s1 <= MUL_W'(coef.px) * col_m;
			p_py_s1 <= MUL_W'(coef.py) * row_m;
			c_x_s1  <= coef.xc;
			c_y_s1  <= coef.yc;
			ok_s1   <= (32'(src_col) < SRC_SPAN) && (32'(src_row) < SRC_SPAN);
			clr_s1  <= color;

			n_x_s2 <= SUM_W'(p_xx_s1) + SUM_W'(p_xy_s1) + SUM_W'(c_x_s1);
			n_y_s2 <= SUM_W'(p_yx_s1) + SUM_W'(p_yy_s1) + SUM_W'(c_y_s1);
			d_s2   <= SUM_W'(p_px_s1) + SUM_W'(p_py_s1) + ONE_Q30;
			ok_s2  <= ok_s1;
			clr_s2 <= clr_s1;

			// quotient sign depends on both numerator and denominator
			sgn_x_s3 <= n_x_s2[SUM_W-1] ^ d_s2[SUM_W-1];
			sgn_y_s3 <= n_y_s2[SUM_W-1] ^ d_s2[SUM_W-1];
			num_x_s3 <= {(n_x_s2[SUM_W-1] ? -n_x_s2 : n_x_s2), 10'b0};
			num_y_s3 <= {(n_y_s2[SUM_W-1] ? -n_y_s2 : n_y_s2), 10'b0};
			den_s3   <= d_s2[SUM_W-1] ? -d_s2 : d_s2;
			zero_s3  <= (d_s2 == '0);
			ok_s3    <= ok_s2;
			clr_s3   <= clr_s2;
		end
	end

	assign res = '{vld: vld_s3, num_x: num_x_s3, num_y: num_y_s3, den: den_s3,
		sgn_x: sgn_x_s3, sgn_y: sgn_y_s3, den_zero: zero_s3, src_ok: ok_s3,
		color: clr_s3};

endmodule

FILE: hw/rtl/hpm_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Depends on hpm_pkg.
module hpm_div
	import hpm_pkg::*;
#(
	parameter int QB = 9,
	parameter int TW = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [TW-1:0]    tag,
	output logic             out_vld,
	output logic [QB-1:0]    quo,
	output logic             ovf,
	output logic [TW-1:0]    tag_out
);

	localparam int CW = NUM_W + QB;

	logic [QB:0]          vld_s;
	logic [CW-1:0]        rem_s [QB+1];
	logic [DEN_W-1:0]     dv_s  [QB+1];
	logic [QB-1:0]        q_s   [QB+1];
	logic                 ovf_s [QB+1];
	logic [TW-1:0]        tag_s [QB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[QB-1:0], in_vld};
		end
	end

	// entry stage: quotient >= 2^QB is flagged and not resolved further
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= CW'(num);
			dv_s[0]  <= den;
			q_s[0]   <= '0;
			ovf_s[0] <= CW'(num) >= (CW'(den) << QB);
			tag_s[0] <= tag;
		end
	end

	for (genvar j = 1; j <= QB; j++) begin : g_step
		localparam int K = QB - j;
		logic [CW-1:0] sh;
		logic          ge;

		assign sh = CW'(dv_s[j-1]) << K;
		assign ge = rem_s[j-1] >= sh;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= ge ? rem_s[j-1] - sh : rem_s[j-1];
				dv_s[j]  <= dv_s[j-1];
				q_s[j]   <= q_s[j-1] | (QB'(ge) << K);
				ovf_s[j] <= ovf_s[j-1];
				tag_s[j] <= tag_s[j-1];
			end
		end
	end

	assign out_vld = vld_s[QB];
	assign quo     = q_s[QB];
	assign ovf     = ovf_s[QB];
	assign tag_out = tag_s[QB];

endmodule

FILE: hw/rtl/homography_forward_pixel_mapper.sv
// Top level of the homography forward pixel mapper: config registers,
// MAC front end, two dividers, output register. Depends on hpm_pkg, hpm_mac, hpm_div.
//
//  channel | handshake            | word
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_stall  | src_col, src_row, blue/green/red_in
//  out     | out_valid / out_stall| dst_col, dst_row, blue/green/red_out, inside_res
//  cfg     | cfg_we               | cfg_index, cfg_data (no read-back)
//
// One word per clock unless a finished output word is stalled. Pipeline stages, with QB =
// clog2(max(DST_WIDTH, DST_HEIGHT)): three MAC stages, one overflow stage,
// one divider stage per quotient bit, one output register.
// Reset clears valid bits and loads the identity homography.
// A stalled output word freezes the whole pipeline; in_stall follows it.
module homography_forward_pixel_mapper
	import hpm_pkg::*;
#(
	parameter int DST_WIDTH  = DEF_DST_WIDTH,
	parameter int DST_HEIGHT = DEF_DST_HEIGHT,
	parameter int SRC_SPAN   = DEF_SRC_SPAN,
	localparam int COL_W = (DST_WIDTH  > 1) ? $clog2(DST_WIDTH)  : 1,
	localparam int ROW_W = (DST_HEIGHT > 1) ? $clog2(DST_HEIGHT) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [CRD_W-1:0]  src_col,
	input  logic [CRD_W-1:0]  src_row,
	input  logic [CLR_W-1:0]  blue_in,
	input  logic [CLR_W-1:0]  green_in,
	input  logic [CLR_W-1:0]  red_in,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [COL_W-1:0]  dst_col,
	output logic [ROW_W-1:0]  dst_row,
	output logic [CLR_W-1:0]  blue_out,
	output logic [CLR_W-1:0]  green_out,
	output logic [CLR_W-1:0]  red_out,
	output logic              inside_res,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [COEF_W-1:0] cfg_data
);

	localparam int DMAX = (DST_WIDTH > DST_HEIGHT) ? DST_WIDTH : DST_HEIGHT;
	localparam int QB   = (DMAX > 1) ? $clog2(DMAX) : 1;
	localparam int TW   = 3 * CLR_W + 3;

	coef_t    coef_q;
	mac_res_t mac;
	logic     en;

	logic              vld_x, vld_y, ovf_x, ovf_y;
	logic [QB-1:0]     q_x, q_y;
	logic [TW-1:0]     tag_x;
	logic              sgn_y_d;
	logic              in_x, in_y, in_dst;
	logic              sgn_x_d, zero_d, ok_d;
	logic [3*CLR_W-1:0] clr_d;

	// whole pipeline advances unless a finished word is held at the output
	assign in_stall = out_valid & out_stall;
	assign en       = ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '{xx: 32'sh0010_0000, yy: 32'sh0010_0000, default: '0};
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_XX: coef_q.xx <= cfg_data;
				REG_XY: coef_q.xy <= cfg_data;
				REG_XC: coef_q.xc <= cfg_data;
				REG_YX: coef_q.yx <= cfg_data;
				REG_YY: coef_q.yy <= cfg_data;
				REG_YC: coef_q.yc <= cfg_data;
				REG_PX: coef_q.px <= cfg_data;
				REG_PY: coef_q.py <= cfg_data;
				default: ;
			endcase
		end
	end

	hpm_mac #(
		.SRC_SPAN(SRC_SPAN)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (in_valid),
		.src_col (src_col),
		.src_row (src_row),
		.color   ({blue_in, green_in, red_in}),
		.coef    (coef_q),
		.res     (mac)
	);

	// x divider carries the side data; y divider carries only its sign
	hpm_div #(
		.QB(QB),
		.TW(TW)
	) u_div_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (mac.vld),
		.num     (mac.num_x),
		.den     (mac.den),
		.tag     ({mac.sgn_x, mac.den_zero, mac.src_ok, mac.color}),
		.out_vld (vld_x),
		.quo     (q_x),
		.ovf     (ovf_x),
		.tag_out (tag_x)
	);

	hpm_div #(
		.QB(QB),
		.TW(1)
	) u_div_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (mac.vld),
		.num     (mac.num_y),
		.den     (mac.den),
		.tag     (mac.sgn_y),
		.out_vld (vld_y),
		.quo     (q_y),
		.ovf     (ovf_y),
		.tag_out (sgn_y_d)
	);

	assign {sgn_x_d, zero_d, ok_d, clr_d} = tag_x;

	// negative quotient is inside only when it truncates to zero
	always_comb begin
		in_x = sgn_x_d ? (!ovf_x && q_x == '0) : (!ovf_x && 32'(q_x) < DST_WIDTH);
		in_y = sgn_y_d ? (!ovf_y && q_y == '0) : (!ovf_y && 32'(q_y) < DST_HEIGHT);
		in_dst = ok_d && (zero_d || (in_x && in_y));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_x;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dst_col    <= (in_dst && !zero_d) ? q_x[COL_W-1:0] : '0;
			dst_row    <= (in_dst && !zero_d) ? q_y[ROW_W-1:0] : '0;
			{blue_out, green_out, red_out} <= clr_d;
			inside_res <= in_dst;
		end
	end

	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		vld_x == vld_y) else $error("divider valids diverged");

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !inside_res |-> dst_col == '0 && dst_row == '0)
		else $error("outside word with nonzero coordinate");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(vld_x) && $stable(q_x))
		else $error("pipeline moved under stall");

endmodule

FILE: sim/hpm_checker.sv
// Checker for the homography forward pixel mapper: watches both channels,
// predicts each output word from its own register copy and compares.
// Depends on hpm_pkg.
`timescale 1ns / 100ps
module hpm_checker
	import hpm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [CRD_W-1:0]  src_col,
	input  logic [CRD_W-1:0]  src_row,
	input  logic [CLR_W-1:0]  blue_in,
	input  logic [CLR_W-1:0]  green_in,
	input  logic [CLR_W-1:0]  red_in,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [8:0]        dst_col,
	input  logic [8:0]        dst_row,
	input  logic [CLR_W-1:0]  blue_out,
	input  logic [CLR_W-1:0]  green_out,
	input  logic [CLR_W-1:0]  red_out,
	input  logic              inside_res,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [COEF_W-1:0] cfg_data,
	output int                fail_count,
	output int                pending
);

	typedef struct packed {
		logic [8:0] col;
		logic [8:0] row;
		logic [7:0] b;
		logic [7:0] g;
		logic [7:0] r;
		logic       in_dst;
	} mapped_px_t;

	coef_t      h;
	mapped_px_t mapped_q[$];

	function automatic mapped_px_t map_pixel(input logic [CRD_W-1:0] c,
		input logic [CRD_W-1:0] r, input logic [7:0] b, input logic [7:0] g,
		input logic [7:0] rd);
		longint x, y, nx, ny, den, qx, qy;
		mapped_px_t m;
		x = c;
		y = r;
		nx = longint'(h.xx) * x + longint'(h.xy) * y + longint'(h.xc);
		ny = longint'(h.yx) * x + longint'(h.yy) * y + longint'(h.yc);
		den = longint'(h.px) * x + longint'(h.py) * y + (64'sd1 << 30);
		// numerators fit in 46 bits, so the 2^10 scale stays inside 64
		if (den == 0) begin
			qx = 0;
			qy = 0;
		end else begin
			qx = (nx * 1024) / den;
			qy = (ny * 1024) / den;
		end
		m.in_dst = x < DEF_SRC_SPAN && y < DEF_SRC_SPAN && qx >= 0
			&& qx < DEF_DST_WIDTH && qy >= 0 && qy < DEF_DST_HEIGHT;
		m.col = m.in_dst ? qx[8:0] : '0;
		m.row = m.in_dst ? qy[8:0] : '0;
		m.b = b;
		m.g = g;
		m.r = rd;
		return m;
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		mapped_px_t w;
		if (!arst_n) begin
			h <= '{xx: 32'sh0010_0000, yy: 32'sh0010_0000, default: '0};
			fail_count = 0;
			mapped_q.delete();
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
				REG_XX: h.xx <= cfg_data;
				REG_XY: h.xy <= cfg_data;
				REG_XC: h.xc <= cfg_data;
				REG_YX: h.yx <= cfg_data;
				REG_YY: h.yy <= cfg_data;
				REG_YC: h.yc <= cfg_data;
				REG_PX: h.px <= cfg_data;
				REG_PY: h.py <= cfg_data;
				endcase
			end
			if (in_valid && !in_stall)
				mapped_q = {mapped_q,
					map_pixel(src_col, src_row, blue_in, green_in, red_in)};
			if (out_valid && !out_stall) begin
				if (mapped_q.size() == 0) begin
					report("extra output word", 1, 0);
				end else begin
					w = mapped_q.pop_front();
					if (dst_col !== w.col) report("dst_col", dst_col, w.col);
					if (dst_row !== w.row) report("dst_row", dst_row, w.row);
					if (blue_out !== w.b) report("blue_out", blue_out, w.b);
					if (green_out !== w.g) report("green_out", green_out, w.g);
					if (red_out !== w.r) report("red_out", red_out, w.r);
					if (inside_res !== w.in_dst)
						report("inside_res", inside_res, w.in_dst);
				end
			end
			pending = mapped_q.size();
		end
	end

endmodule

FILE: sim/tb_top.sv
// Testbench top of the homography forward pixel mapper: clock, reset,
// register phases and pixel stimulus; checking lives in hpm_checker.
// Depends on hpm_pkg, hpm_checker and the mapper RTL.
`timescale 1ns / 100ps
module tb_top;
	import hpm_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [CRD_W-1:0]  src_col;
	logic [CRD_W-1:0]  src_row;
	logic [CLR_W-1:0]  blue_in;
	logic [CLR_W-1:0]  green_in;
	logic [CLR_W-1:0]  red_in;
	logic              out_valid;
	logic              out_stall;
	logic [8:0]        dst_col;
	logic [8:0]        dst_row;
	logic [CLR_W-1:0]  blue_out;
	logic [CLR_W-1:0]  green_out;
	logic [CLR_W-1:0]  red_out;
	logic              inside_res;
	logic              cfg_we;
	logic [2:0]        cfg_index;
	logic [COEF_W-1:0] cfg_data;
	int                fail_count;
	int                pending;
	logic              hold_off;	// long receiver stall in progress

	homography_forward_pixel_mapper u_dut (.*);
	hpm_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Gap lengths: mostly none or short, now and then long.
	function automatic int pick_gap();
		int p;
		p = $urandom_range(99);
		if (p < 55) return 0;
		if (p < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Receiver: random stalls, plus a long hold-off when requested so the
	// pipeline fills and backs up into in_stall.
	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (200) @(posedge clk);
				hold_off = 1'b0;
			end
			n = pick_gap();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			n = $urandom_range(1, 12);
			repeat (n) @(posedge clk);
		end
	end

	// Offer one pixel word and hold it until accepted.
	task automatic send_pixel(input logic [10:0] c, input logic [10:0] r,
		input logic [7:0] b, input logic [7:0] g, input logic [7:0] rd, input bit gaps);
		int n;
		n = gaps ? pick_gap() : 0;
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		src_col <= c;
		src_row <= r;
		blue_in <= b;
		green_in <= g;
		red_in <= rd;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_random(input int count, input bit near);
		logic [10:0] c, r;
		repeat (count) begin
			// with near, coordinates up to 600, mostly inside 512x512; else full span
			c = near ? 11'($urandom_range(0, 600)) : 11'($urandom);
			r = near ? 11'($urandom_range(0, 600)) : 11'($urandom);
			send_pixel(c, r, 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
		end
	endtask

	// Idle the input, drain all expected words, then let the pipe settle.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// Write enable stays high across back-to-back writes; caller drops it.
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic load_homography(input logic [31:0] v[8]);
		for (int i = 0; i < 8; i++) write_reg(reg_idx_t'(i), v[i]);
		cfg_we <= 1'b0;
	endtask

	// Back to identity with small random offsets so most words land inside.
	task automatic ref_idents(output logic [31:0] v[8]);
		v = '{32'h0010_0000, 32'h0000_0000, 32'($urandom_range(0, 32'h0100_0000)),
			32'h0000_0000, 32'h0010_0000, 32'($urandom_range(0, 32'h0100_0000)),
			32'h0000_0000, 32'h0000_0000};
		load_homography(v);
	endtask

	initial begin
		logic [31:0] hv[8];
		arst_n = 1'b0;
		in_valid = 1'b0;
		src_col = '0;
		src_row = '0;
		blue_in = '0;
		green_in = '0;
		red_in = '0;
		cfg_we = 1'b0;
		cfg_index = REG_XX;
		cfg_data = '0;
		hold_off = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, identity mapping: corners, span edge, colour extremes.
		send_pixel(11'd0, 11'd0, 8'h00, 8'hFF, 8'h00, 1'b0);
		send_pixel(11'd511, 11'd511, 8'hFF, 8'h00, 8'hFF, 1'b0);
		send_pixel(11'd512, 11'd0, 8'hAA, 8'h55, 8'hAA, 1'b0);
		send_pixel(11'd0, 11'd512, 8'h55, 8'hAA, 8'h55, 1'b0);
		send_pixel(11'd2047, 11'd2047, 8'hFF, 8'hFF, 8'hFF, 1'b0);
		send_pixel(11'd1024, 11'd300, 8'h01, 8'h80, 8'h7F, 1'b0);
		drain();

		// Zero denominator at x=1024: persp_x = -2^30/1024 = -2^20.
		hv = '{32'h0020_0000, 32'h0008_0000, 32'h0100_0000, 32'hFFF0_0000,
			32'h0010_0000, 32'h00A0_0000, 32'hFFF0_0000, 32'h0000_0000};
		load_homography(hv);
		send_pixel(11'd1024, 11'd7, 8'h12, 8'h34, 8'h56, 1'b0);
		send_pixel(11'd1024, 11'd2047, 8'h9A, 8'hBC, 8'hDE, 1'b0);
		send_pixel(11'd1023, 11'd3, 8'h00, 8'h00, 8'h00, 1'b0);
		send_pixel(11'd1025, 11'd3, 8'hFF, 8'hFF, 8'hFF, 1'b0);
		send_pixel(11'd10, 11'd10, 8'h0F, 8'hF0, 8'h3C, 1'b0);
		drain();

		// Register extremes: most negative and most positive.
		hv = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
		load_homography(hv);
		send_pixel(11'd0, 11'd0, 8'h00, 8'h00, 8'h00, 1'b0);
		send_pixel(11'd2047, 11'd0, 8'hFF, 8'h00, 8'h00, 1'b0);
		send_pixel(11'd0, 11'd2047, 8'h00, 8'hFF, 8'h00, 1'b0);
		send_pixel(11'd2047, 11'd2047, 8'h00, 8'h00, 8'hFF, 1'b0);
		send_pixel(11'd1, 11'd1, 8'h5A, 8'hA5, 8'h5A, 1'b0);
		drain();

		// Random phases: scaled/rotated, mild perspective, fully random, then identity with offsets.
		hv = '{32'h0008_0000, 32'h0000_4000, 32'h0020_0000, 32'hFFFF_C000,
			32'h0008_0000, 32'h0010_0000, 32'h0000_0100, 32'h0000_0080};
		load_homography(hv);
		fork
			begin
				repeat (60) @(posedge clk);
				hold_off = 1'b1;
			end
			send_random(300, 1'b0);
		join
		drain();

		hv = '{32'h0010_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
			32'h0010_0000, 32'h0000_0000, 32'hFFFF_8000, 32'h0001_0000};
		hv[2] = 32'($urandom_range(0, 32'h0200_0000));
		hv[5] = 32'($urandom_range(0, 32'h0200_0000));
		load_homography(hv);
		send_random(300, 1'b1);
		drain();

		for (int i = 0; i < 8; i++) hv[i] = $urandom;
		load_homography(hv);
		send_random(150, 1'b0);
		drain();

		ref_idents(hv);
		send_random(180, 1'b1);
		drain();

		if (fail_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		#5ms;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/hpm_pkg.sv
hw/rtl/hpm_mac.sv
hw/rtl/hpm_div.sv
hw/rtl/homography_forward_pixel_mapper.sv
sim/hpm_checker.sv
sim/tb_top.sv
